@@ rtl/apc_pkg.sv @@
// Shared types, constants and helper functions for the axis PID controller.
`timescale 1ns / 1ps
`default_nettype none

package apc_pkg;

  // Number of axes carried in the gain tables
  localparam int TblAxes     = 3;
  localparam int AxesDefault = 3;

  // Ground decay multiplier, 13107 / 2^14 is about 0.8
  localparam logic signed [17:0] DecayMul = 18'sd13107;

  // Largest limit the 16-bit fields can carry
  localparam logic [14:0] LimitMax = 15'h7fff;

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    RegKp       = 3'd0,
    RegWeight   = 3'd1,
    RegKiDt     = 3'd2,
    RegKdDt     = 3'd3,
    RegOutLimit = 3'd4,
    RegIntLimit = 3'd5
  } apc_reg_e;

  // Controller sequencer states
  typedef enum logic [3:0] {
    StIdle,
    StLoad,
    StDecay,
    StInteg,
    StSum,
    StClamp,
    StPTerm,
    StPSum,
    StDTerm,
    StRound,
    StWrite,
    StNull
  } apc_state_e;

  // All gain and limit tables, three 16-bit fields each
  typedef struct packed {
    logic [47:0] kp;
    logic [47:0] weight;
    logic [47:0] ki_dt;
    logic [47:0] kd_dt;
    logic [47:0] out_limit;
    logic [47:0] int_limit;
  } apc_tables_t;

  // Per-axis state word held in the state memory
  typedef struct packed {
    logic [15:0] integ;
    logic [15:0] perr;
    logic [15:0] pdrv;
    logic [15:0] hist0;
    logic [15:0] hist1;
  } apc_word_t;

  // Pick the 16-bit field of one axis out of a table
  function automatic logic [15:0] field16(logic [47:0] tbl, logic [1:0] ax);
    logic [15:0] f;
    case (ax)
      2'd0:    f = tbl[15:0];
      2'd1:    f = tbl[31:16];
      2'd2:    f = tbl[47:32];
      default: f = '0;
    endcase
    return f;
  endfunction

  // Limits above the signed 16-bit range act as the largest value
  function automatic logic [14:0] eff_limit(logic [15:0] l);
    return l[15] ? LimitMax : l[14:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/apc_cfg.sv @@
// APB-style register file holding the gain and limit tables.
`timescale 1ns / 1ps
`default_nettype none

module apc_cfg (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [5:0]         paddr,
  input  wire logic [63:0]        pwdata,
  output logic      [63:0]        prdata,
  output logic                    pready,
  output apc_pkg::apc_tables_t    tables_o
);

  apc_pkg::apc_tables_t tables_q;
  apc_pkg::apc_reg_e    reg_sel;
  logic                 wr_en;

  assign pready   = 1'b1;
  assign reg_sel  = apc_pkg::apc_reg_e'(paddr[5:3]);
  assign wr_en    = psel && penable && pwrite;
  assign tables_o = tables_q;

  // Register writes, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tables_q <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        apc_pkg::RegKp:       tables_q.kp        <= pwdata[47:0];
        apc_pkg::RegWeight:   tables_q.weight    <= pwdata[47:0];
        apc_pkg::RegKiDt:     tables_q.ki_dt     <= pwdata[47:0];
        apc_pkg::RegKdDt:     tables_q.kd_dt     <= pwdata[47:0];
        apc_pkg::RegOutLimit: tables_q.out_limit <= pwdata[47:0];
        apc_pkg::RegIntLimit: tables_q.int_limit <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_sel)
      apc_pkg::RegKp:       prdata = {16'b0, tables_q.kp};
      apc_pkg::RegWeight:   prdata = {16'b0, tables_q.weight};
      apc_pkg::RegKiDt:     prdata = {16'b0, tables_q.ki_dt};
      apc_pkg::RegKdDt:     prdata = {16'b0, tables_q.kd_dt};
      apc_pkg::RegOutLimit: prdata = {16'b0, tables_q.out_limit};
      apc_pkg::RegIntLimit: prdata = {16'b0, tables_q.int_limit};
      default:              prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/apc_mem.sv @@
// Per-axis state memory with a registered read; entries read as zero until written.
`timescale 1ns / 1ps
`default_nettype none

module apc_mem #(
  parameter int AXES = apc_pkg::AxesDefault,
  localparam int AW  = (AXES > 1) ? $clog2(AXES) : 1
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                rd_en_i,
  input  wire logic [AW-1:0]       rd_addr_i,
  output apc_pkg::apc_word_t       rd_data_o,
  input  wire logic                wr_en_i,
  input  wire logic [AW-1:0]       wr_addr_i,
  input  wire apc_pkg::apc_word_t  wr_data_i
);

  apc_pkg::apc_word_t mem_q [AXES];
  apc_pkg::apc_word_t rd_data_q;
  logic [AXES-1:0]    valid_q;
  logic               rd_valid_q;

  // Storage array
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // Written-entry flags, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

`default_nettype wire

@@ rtl/apc_core.sv @@
// Sequencer and shared-multiplier datapath of the PID update.
`timescale 1ns / 1ps
`default_nettype none

module apc_core #(
  parameter int AXES = apc_pkg::AxesDefault,
  localparam int AW  = (AXES > 1) ? $clog2(AXES) : 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire apc_pkg::apc_tables_t  tables_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [1:0]            axis_i,
  input  wire logic signed [15:0]    rate_error_i,
  input  wire logic signed [15:0]    measured_rate_i,
  input  wire logic                  on_ground_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic signed [15:0]         drive_o,
  output logic                       windup_hold_o,
  output logic                       rd_en_o,
  output logic [AW-1:0]              rd_addr_o,
  input  wire apc_pkg::apc_word_t    rd_data_i,
  output logic                       wr_en_o,
  output logic [AW-1:0]              wr_addr_o,
  output apc_pkg::apc_word_t         wr_data_o
);

  apc_pkg::apc_state_e state_q, state_d;

  // Captured sample
  logic [1:0]         axis_q;
  logic signed [15:0] e_q, g_q;
  logic               ground_q;

  // Axis gains and effective limits
  logic [15:0] kp_q, wt_q, ki_q, kd_q;
  logic [14:0] lo_q, li_q;

  // Working registers
  apc_pkg::apc_word_t st_q;
  logic signed [15:0] integ_q;
  logic signed [23:0] sum_q;
  logic signed [53:0] acc_q;
  logic signed [30:0] rnd_q;
  logic               hold_q;

  // Shared multiplier
  logic signed [33:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [51:0] p_q;

  // Output register
  logic               out_valid_q;
  logic signed [15:0] drive_q;
  logic               hold_out_q;

  logic               accept, axis_ok, slot_free;
  logic signed [16:0] err_sum, rate_sum, rate_diff;
  logic signed [16:0] lo_s, li_s;
  logic signed [15:0] pd_s, pe_s, h1_s;
  logic               hold_d;
  logic signed [51:0] dec_r, int_r;
  logic signed [23:0] sum_d;
  logic signed [15:0] integ_clamp;
  logic signed [53:0] p_ext, rnd_r;
  logic signed [15:0] drive_d;

  assign accept    = in_valid_i && in_ready_o;
  assign axis_ok   = (32'(axis_i) < 32'(AXES)) && (32'(axis_i) < 32'(apc_pkg::TblAxes));
  assign slot_free = !out_valid_q || out_ready_i;

  // Operand sums
  assign pe_s      = $signed(st_q.perr);
  assign pd_s      = $signed(st_q.pdrv);
  assign h1_s      = $signed(st_q.hist1);
  assign err_sum   = 17'(e_q) + 17'(pe_s);
  assign rate_sum  = 17'(e_q) + 17'(g_q);
  assign rate_diff = 17'(g_q) - 17'(h1_s);
  assign lo_s      = $signed({2'b00, lo_q});
  assign li_s      = $signed({2'b00, li_q});

  // Anti-windup: previous drive pinned at a limit and error pushing outward
  assign hold_d = ((17'(pd_s) == lo_s) && !e_q[15] && (e_q != '0)) ||
                  ((17'(pd_s) == -lo_s) && e_q[15]);

  // Rounded shifts of the product
  assign dec_r = (p_q + 52'sd8192) >>> 14;
  assign int_r = (p_q + 52'sd2048) >>> 12;
  assign sum_d = hold_q ? 24'(integ_q) : 24'(integ_q) + int_r[23:0];
  assign p_ext = 54'(p_q);
  assign rnd_r = (acc_q + 54'sd4194304) >>> 23;

  // Integral clamp
  always_comb begin
    if (sum_q > 24'(li_s)) begin
      integ_clamp = 16'(li_s);
    end else if (sum_q < -24'(li_s)) begin
      integ_clamp = 16'(-li_s);
    end else begin
      integ_clamp = sum_q[15:0];
    end
  end

  // Drive clamp
  always_comb begin
    if (rnd_q > 31'(lo_s)) begin
      drive_d = 16'(lo_s);
    end else if (rnd_q < -31'(lo_s)) begin
      drive_d = 16'(-lo_s);
    end else begin
      drive_d = rnd_q[15:0];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      apc_pkg::StIdle:  if (accept) state_d = axis_ok ? apc_pkg::StLoad : apc_pkg::StNull;
      apc_pkg::StLoad:  state_d = apc_pkg::StDecay;
      apc_pkg::StDecay: state_d = apc_pkg::StInteg;
      apc_pkg::StInteg: state_d = apc_pkg::StSum;
      apc_pkg::StSum:   state_d = apc_pkg::StClamp;
      apc_pkg::StClamp: state_d = apc_pkg::StPTerm;
      apc_pkg::StPTerm: state_d = apc_pkg::StPSum;
      apc_pkg::StPSum:  state_d = apc_pkg::StDTerm;
      apc_pkg::StDTerm: state_d = apc_pkg::StRound;
      apc_pkg::StRound: state_d = apc_pkg::StWrite;
      apc_pkg::StWrite: if (slot_free) state_d = apc_pkg::StIdle;
      apc_pkg::StNull:  if (slot_free) state_d = apc_pkg::StIdle;
      default:          state_d = apc_pkg::StIdle;
    endcase
  end

  // State outputs: handshake, memory strobes, multiplier operands
  always_comb begin
    in_ready_o = 1'b0;
    rd_en_o    = 1'b0;
    wr_en_o    = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    case (state_q)
      apc_pkg::StIdle: begin
        in_ready_o = 1'b1;
        rd_en_o    = in_valid_i && axis_ok;
      end
      apc_pkg::StDecay: begin
        mul_a = 34'($signed(st_q.integ));
        mul_b = apc_pkg::DecayMul;
      end
      apc_pkg::StInteg: begin
        mul_a = 34'(err_sum);
        mul_b = $signed({2'b00, ki_q});
      end
      apc_pkg::StSum: begin
        mul_a = $signed({18'b0, kp_q});
        mul_b = $signed({2'b00, wt_q});
      end
      apc_pkg::StClamp: begin
        mul_a = $signed({2'b00, p_q[31:0]});
        mul_b = 18'(rate_sum);
      end
      apc_pkg::StPTerm: begin
        mul_a = $signed({18'b0, kp_q});
        mul_b = 18'(e_q);
      end
      apc_pkg::StPSum: begin
        mul_a = 34'(rate_diff);
        mul_b = $signed({2'b00, kd_q});
      end
      apc_pkg::StWrite: wr_en_o = slot_free;
      default: ;
    endcase
  end

  // Memory addressing and write-back word
  assign rd_addr_o       = AW'(axis_i);
  assign wr_addr_o       = AW'(axis_q);
  assign wr_data_o.integ = integ_q;
  assign wr_data_o.perr  = hold_q ? st_q.perr : e_q;
  assign wr_data_o.pdrv  = drive_d;
  assign wr_data_o.hist0 = g_q;
  assign wr_data_o.hist1 = st_q.hist0;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= apc_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (((state_q == apc_pkg::StWrite) || (state_q == apc_pkg::StNull)) && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    p_q <= 52'(mul_a) * 52'(mul_b);
    case (state_q)
      apc_pkg::StIdle: begin
        if (accept) begin
          axis_q   <= axis_i;
          e_q      <= rate_error_i;
          g_q      <= measured_rate_i;
          ground_q <= on_ground_i;
        end
      end
      apc_pkg::StLoad: begin
        st_q <= rd_data_i;
        kp_q <= apc_pkg::field16(tables_i.kp, axis_q);
        wt_q <= apc_pkg::field16(tables_i.weight, axis_q);
        ki_q <= apc_pkg::field16(tables_i.ki_dt, axis_q);
        kd_q <= apc_pkg::field16(tables_i.kd_dt, axis_q);
        lo_q <= apc_pkg::eff_limit(apc_pkg::field16(tables_i.out_limit, axis_q));
        li_q <= apc_pkg::eff_limit(apc_pkg::field16(tables_i.int_limit, axis_q));
      end
      apc_pkg::StInteg: begin
        integ_q <= ground_q ? dec_r[15:0] : $signed(st_q.integ);
        hold_q  <= hold_d;
      end
      apc_pkg::StSum:   sum_q   <= sum_d;
      apc_pkg::StClamp: integ_q <= integ_clamp;
      apc_pkg::StPTerm: acc_q   <= -p_ext;
      apc_pkg::StPSum:  acc_q   <= acc_q + (p_ext <<< 12);
      apc_pkg::StDTerm: begin
        acc_q <= acc_q + {{15{integ_q[15]}}, integ_q, 23'b0} - (p_ext <<< 11);
      end
      apc_pkg::StRound: rnd_q <= rnd_r[30:0];
      apc_pkg::StWrite: begin
        if (slot_free) begin
          drive_q    <= drive_d;
          hold_out_q <= hold_q;
        end
      end
      apc_pkg::StNull: begin
        if (slot_free) begin
          drive_q    <= '0;
          hold_out_q <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign drive_o       = drive_q;
  assign windup_hold_o = hold_out_q;

endmodule

`default_nettype wire

@@ rtl/axis_pid_controller_unit.sv @@
// A word for a valid axis goes through load, decay, integ, sum, clamp, p-term, p-sum, d-term, round
// and write, with six passes through the one shared multiplier plus the state memory read and
// write-back; an invalid axis goes to null. No new word is taken until the last has reached the output.
// Reset: asynchronous, active low; clears all tables, the sequencer and the output valid flag,
// and marks every axis state entry as zero until it is first written (no clearing pass).
// Configuration is taken on any cycle with pready always high.
`timescale 1ns / 1ps
`default_nettype none

module axis_pid_controller_unit #(
  parameter int AXES = apc_pkg::AxesDefault,
  localparam int AW  = (AXES > 1) ? $clog2(AXES) : 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [5:0]         paddr,
  input  wire logic [63:0]        pwdata,
  output logic      [63:0]        prdata,
  output logic                    pready,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         axis_i,
  input  wire logic signed [15:0] rate_error_i,
  input  wire logic signed [15:0] measured_rate_i,
  input  wire logic               on_ground_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [15:0]      drive_o,
  output logic                    windup_hold_o
);

  apc_pkg::apc_tables_t tables;
  apc_pkg::apc_word_t   rd_data, wr_data;
  logic                 rd_en, wr_en;
  logic [AW-1:0]        rd_addr, wr_addr;

  // Gain and limit registers
  apc_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .tables_o (tables)
  );

  // Per-axis state store
  apc_mem #(.AXES(AXES)) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  // Update sequencer and datapath
  apc_core #(.AXES(AXES)) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .tables_i        (tables),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .axis_i          (axis_i),
    .rate_error_i    (rate_error_i),
    .measured_rate_i (measured_rate_i),
    .on_ground_i     (on_ground_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .drive_o         (drive_o),
    .windup_hold_o   (windup_hold_o),
    .rd_en_o         (rd_en),
    .rd_addr_o       (rd_addr),
    .rd_data_i       (rd_data),
    .wr_en_o         (wr_en),
    .wr_addr_o       (wr_addr),
    .wr_data_o       (wr_data)
  );

endmodule

`default_nettype wire
